// File: rtl/asc_pkg.sv
package asc_pkg;

   // activity codes
   typedef enum logic [1:0] {
      ACT_IDLE    = 2'd0,
      ACT_MOVING  = 2'd1,
      ACT_WALKING = 2'd2
   } activity_type;

   // register indexes of the csr port
   typedef enum logic [2:0] {
      CSR_GRAVITY   = 3'd0,
      CSR_THRESHOLD = 3'd1,
      CSR_IDLE_CONF = 3'd2,
      CSR_WALK_TOUT = 3'd3,
      CSR_IDLE_POLL = 3'd4,
      CSR_MOVE_POLL = 3'd5
   } csr_index_type;

   localparam int RunWidth   = 8;
   localparam int CountWidth = 8;
   localparam int CmpWidth   = (RunWidth > CountWidth) ? RunWidth : CountWidth;
   localparam logic [RunWidth-1:0] RunMax = {RunWidth{1'b1}};

   localparam int QDepth     = 4;
   localparam int QPtrWidth  = 2;
   localparam int QCntWidth  = 3;

   localparam logic [14:0] GravityReset   = 15'd16393;
   localparam logic [14:0] ThresholdReset = 15'd1000;
   localparam logic [7:0]  IdleConfReset  = 8'd10;
   localparam logic [7:0]  WalkToutReset  = 8'd10;
   localparam logic [15:0] IdlePollReset  = 16'd1000;
   localparam logic [15:0] MovePollReset  = 16'd100;

   typedef struct packed {
      logic [14:0] gravity_lsb;
      logic [14:0] motion_threshold_lsb;
      logic [7:0]  idle_confirm_count;
      logic [7:0]  walking_timeout_count;
      logic [15:0] idle_poll_ms;
      logic [15:0] moving_poll_ms;
   } cfg_type;

   // classified sample handed from front to back
   typedef struct packed {
      logic        moving;
      logic        accel_ok;
      logic [15:0] step_total;
      logic        step_ok;
   } item_type;

   // queue status seen by front and back
   typedef struct packed {
      logic [QCntWidth-1:0] count;
      logic                 not_empty;
   } q_status_type;

   // saturating run counter step
   function automatic logic [RunWidth-1:0] run_inc(input logic [RunWidth-1:0] v);
      return (v == RunMax) ? RunMax : v + RunWidth'(1);
   endfunction

endpackage

// File: rtl/asc_channels.sv
// sample request channel
interface asc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic               accel_ok;
   logic [15:0]        step_total;
   logic               step_ok;

   modport source (output valid, accel_x, accel_y, accel_z, accel_ok, step_total, step_ok,
                   input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, accel_ok, step_total, step_ok,
                   output ready);
endinterface

// classification result channel
interface asc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  activity;
   logic        moving_now;
   logic        active_sample;
   logic [15:0] step_delta;
   logic [15:0] poll_interval;
   logic        status;

   modport source (output valid, activity, moving_now, active_sample, step_delta,
                   poll_interval, status, input ready);
   modport sink   (input valid, activity, moving_now, active_sample, step_delta,
                   poll_interval, status, output ready);
endinterface

// File: rtl/asc_front.sv
module asc_front (
   input  logic                  clock,
   input  logic                  reset,
   asc_req_if.sink               req,
   input  asc_pkg::cfg_type      cfg,
   input  asc_pkg::q_status_type q_status,
   output logic                  push,
   output asc_pkg::item_type     push_item
);

   logic                              accept;
   logic [asc_pkg::QCntWidth-1:0]     credit_used;

   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic        s1_accel_ok_ff, s1_step_ok_ff;
   logic [15:0] s1_steps_ff;

   logic        s2_valid_ff;
   logic [31:0] sum_ff, sum_in;
   logic        s2_accel_ok_ff, s2_step_ok_ff;
   logic [15:0] s2_steps_ff;

   logic [15:0] hi_bound;
   logic [14:0] lo_bound;
   logic [31:0] hi_sq_ff, hi_sq_in, lo_sq_ff, lo_sq_in;
   logic        lo_en_ff, lo_en_in;

   // space is reserved in the queue for every sample in flight
   assign credit_used = q_status.count
                        + asc_pkg::QCntWidth'(s1_valid_ff)
                        + asc_pkg::QCntWidth'(s2_valid_ff);
   assign req.ready   = (credit_used < asc_pkg::QCntWidth'(asc_pkg::QDepth));
   assign accept      = req.valid && req.ready;
   assign s1_valid_in = accept;

   // squared bounds of the magnitude window
   assign hi_bound = {1'b0, cfg.gravity_lsb} + {1'b0, cfg.motion_threshold_lsb};
   assign lo_bound = cfg.gravity_lsb - cfg.motion_threshold_lsb;
   assign lo_en_in = cfg.gravity_lsb > cfg.motion_threshold_lsb;
   assign hi_sq_in = 32'(hi_bound) * 32'(hi_bound);
   assign lo_sq_in = 32'(lo_bound) * 32'(lo_bound);

   always_ff @(posedge clock) begin
      hi_sq_ff <= hi_sq_in;
      lo_sq_ff <= lo_sq_in;
      lo_en_ff <= lo_en_in;
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // stage 1: per-axis squares
   always_ff @(posedge clock) begin
      sq_x_ff        <= 32'(req.accel_x * req.accel_x);
      sq_y_ff        <= 32'(req.accel_y * req.accel_y);
      sq_z_ff        <= 32'(req.accel_z * req.accel_z);
      s1_accel_ok_ff <= req.accel_ok;
      s1_steps_ff    <= req.step_total;
      s1_step_ok_ff  <= req.step_ok;
   end

   // stage 2: sum of squares, fits 32 bits for three 16-bit axes
   assign sum_in = sq_x_ff + sq_y_ff + sq_z_ff;

   always_ff @(posedge clock) begin
      sum_ff         <= sum_in;
      s2_accel_ok_ff <= s1_accel_ok_ff;
      s2_steps_ff    <= s1_steps_ff;
      s2_step_ok_ff  <= s1_step_ok_ff;
   end

   // motion test against the window, then into the queue
   assign push                 = s2_valid_ff;
   assign push_item.moving     = s2_accel_ok_ff &&
                                 ((sum_ff > hi_sq_ff) || (lo_en_ff && (sum_ff < lo_sq_ff)));
   assign push_item.accel_ok   = s2_accel_ok_ff;
   assign push_item.step_total = s2_steps_ff;
   assign push_item.step_ok    = s2_step_ok_ff;

endmodule

// File: rtl/asc_queue.sv
module asc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  asc_pkg::item_type     push_item,
   input  logic                  pop,
   output asc_pkg::item_type     head_item,
   output asc_pkg::q_status_type q_status
);

   asc_pkg::item_type entry_ff [asc_pkg::QDepth];

   logic [asc_pkg::QPtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [asc_pkg::QPtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [asc_pkg::QCntWidth-1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + asc_pkg::QPtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + asc_pkg::QPtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff + asc_pkg::QCntWidth'(push) - asc_pkg::QCntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item          = entry_ff[rd_ptr_ff];
   assign q_status.count     = count_ff;
   assign q_status.not_empty = (count_ff != '0);

endmodule

// File: rtl/asc_back.sv
module asc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  asc_pkg::cfg_type      cfg,
   input  asc_pkg::q_status_type q_status,
   input  asc_pkg::item_type     head_item,
   output logic                  pop,
   asc_rsp_if.source             rsp
);

   asc_pkg::activity_type         act_ff, act_in;
   logic [asc_pkg::RunWidth-1:0]  quiet_ff, quiet_in;
   logic [asc_pkg::RunWidth-1:0]  stepless_ff, stepless_in;
   logic [15:0]                   baseline_ff, baseline_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    activity_ff;
   logic                          moving_ff, active_ff, status_ff;
   logic [15:0]                   delta_ff, poll_ff;

   logic                          moving_in, active_in, status_in;
   logic [15:0]                   delta_in, poll_in;

   // take the next item when the output register is free or drains
   assign pop          = q_status.not_empty && (!rsp_valid_ff || rsp.ready);
   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp.ready);

   // activity state update for one sample
   always_comb begin
      act_in      = act_ff;
      quiet_in    = quiet_ff;
      stepless_in = stepless_ff;
      baseline_in = baseline_ff;
      moving_in   = 1'b0;
      active_in   = 1'b0;
      status_in   = 1'b0;
      delta_in    = '0;
      if (!head_item.accel_ok) begin
         status_in = 1'b1;
      end else begin
         moving_in = head_item.moving;
         // leaving idle seeds the step baseline
         if (act_ff == asc_pkg::ACT_IDLE && head_item.moving) begin
            act_in      = asc_pkg::ACT_MOVING;
            quiet_in    = '0;
            stepless_in = '0;
            if (head_item.step_ok) begin
               baseline_in = head_item.step_total;
            end
         end
         if (act_in != asc_pkg::ACT_IDLE) begin
            active_in = 1'b1;
            // step tracking
            if (head_item.step_ok) begin
               delta_in    = head_item.step_total - baseline_in;
               baseline_in = head_item.step_total;
               if (delta_in != '0) begin
                  stepless_in = '0;
                  if (act_in == asc_pkg::ACT_MOVING) begin
                     act_in = asc_pkg::ACT_WALKING;
                  end
               end else begin
                  stepless_in = asc_pkg::run_inc(stepless_in);
                  if (act_in == asc_pkg::ACT_WALKING &&
                      asc_pkg::CmpWidth'(stepless_in) >=
                      asc_pkg::CmpWidth'(cfg.walking_timeout_count)) begin
                     act_in = asc_pkg::ACT_MOVING;
                  end
               end
            end
            // quiet tracking
            if (head_item.moving) begin
               quiet_in = '0;
            end else begin
               quiet_in = asc_pkg::run_inc(quiet_in);
               if (asc_pkg::CmpWidth'(quiet_in) >=
                   asc_pkg::CmpWidth'(cfg.idle_confirm_count)) begin
                  act_in = asc_pkg::ACT_IDLE;
               end
            end
         end
      end
      poll_in = (act_in == asc_pkg::ACT_IDLE) ? cfg.idle_poll_ms : cfg.moving_poll_ms;
   end

   // state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= asc_pkg::ACT_IDLE;
         quiet_ff     <= '0;
         stepless_ff  <= '0;
         baseline_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            act_ff      <= act_in;
            quiet_ff    <= quiet_in;
            stepless_ff <= stepless_in;
            baseline_ff <= baseline_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (pop) begin
         activity_ff <= act_in;
         moving_ff   <= moving_in;
         active_ff   <= active_in;
         delta_ff    <= delta_in;
         poll_ff     <= poll_in;
         status_ff   <= status_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.activity      = activity_ff;
   assign rsp.moving_now    = moving_ff;
   assign rsp.active_sample = active_ff;
   assign rsp.step_delta    = delta_ff;
   assign rsp.poll_interval = poll_ff;
   assign rsp.status        = status_ff;

endmodule

// File: rtl/activity_state_classifier_top.sv
// Activity classifier: takes one accelerometer sample with a pedometer count per transfer
// and returns one result (idle, moving or walking, step delta, poll interval) per sample,
// in order. A new sample can be taken every cycle. Each sample passes two front stages (axis
// squares, then sum of squares, followed by the window test), the four-entry queue and the
// output register of the state unit. The front holds back only when the queue together
// with the samples in its stages would be full, which happens when the result side stalls.
// The user must write registers through the csr port only while no sample is in flight;
// the block itself does not enforce this.
module activity_state_classifier_top (
   input  logic        clock,
   input  logic        reset,
   asc_req_if.sink     req_chan,
   asc_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   asc_pkg::cfg_type      cfg_ff;
   asc_pkg::q_status_type q_status;
   asc_pkg::item_type     push_item;
   asc_pkg::item_type     head_item;
   logic                  push;
   logic                  pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gravity_lsb           <= asc_pkg::GravityReset;
         cfg_ff.motion_threshold_lsb  <= asc_pkg::ThresholdReset;
         cfg_ff.idle_confirm_count    <= asc_pkg::IdleConfReset;
         cfg_ff.walking_timeout_count <= asc_pkg::WalkToutReset;
         cfg_ff.idle_poll_ms          <= asc_pkg::IdlePollReset;
         cfg_ff.moving_poll_ms        <= asc_pkg::MovePollReset;
      end else if (csr_we) begin
         case (asc_pkg::csr_index_type'(csr_index))
            asc_pkg::CSR_GRAVITY:   cfg_ff.gravity_lsb           <= csr_wdata[14:0];
            asc_pkg::CSR_THRESHOLD: cfg_ff.motion_threshold_lsb  <= csr_wdata[14:0];
            asc_pkg::CSR_IDLE_CONF: cfg_ff.idle_confirm_count    <= csr_wdata[7:0];
            asc_pkg::CSR_WALK_TOUT: cfg_ff.walking_timeout_count <= csr_wdata[7:0];
            asc_pkg::CSR_IDLE_POLL: cfg_ff.idle_poll_ms          <= csr_wdata;
            asc_pkg::CSR_MOVE_POLL: cfg_ff.moving_poll_ms        <= csr_wdata;
            default: ;
         endcase
      end
   end

   asc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   asc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   asc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .head_item (head_item),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

   // queue never overfills
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= asc_pkg::QCntWidth'(asc_pkg::QDepth))
      else $error("queue count out of range");

   a_q_push: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (q_status.count < asc_pkg::QCntWidth'(asc_pkg::QDepth)))
      else $error("push into full queue");

   // a sample skipped by the active path reports no motion and no steps
   a_skip: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.active_sample) |->
      (!rsp_chan.moving_now && rsp_chan.step_delta == 16'd0))
      else $error("skipped sample carries motion or steps");

   a_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status) |-> !rsp_chan.active_sample)
      else $error("failed read ran the active path");

   // poll interval follows the reported activity
   a_poll: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.activity == asc_pkg::ACT_IDLE) |->
      (rsp_chan.poll_interval == cfg_ff.idle_poll_ms))
      else $error("idle poll interval mismatch");

endmodule

// File: dv/asc_checker.sv
module activity_classifier_checker
   import asc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   asc_req_if          req_chan,
   asc_rsp_if          rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          error_count,
   output int          reports_pending
);

   // one classification report as the result channel carries it
   typedef struct packed {
      activity_type activity;
      logic         moving_now;
      logic         active_sample;
      logic [15:0]  step_delta;
      logic [15:0]  poll_interval;
      logic         status;
   } activity_report_type;

   cfg_type               cfg;
   activity_type          act_state;
   logic [RunWidth-1:0]   quiet_run;
   logic [RunWidth-1:0]   stepless_run;
   logic [15:0]           step_base;
   activity_report_type   activity_reports[$];
   int                    errors = 0;

   // run counters stick at all ones
   function automatic logic [RunWidth-1:0] sat_incr(input logic [RunWidth-1:0] v);
      return (v == {RunWidth{1'b1}}) ? v : v + 1'b1;
   endfunction

   // magnitude outside the window around one g, squared to avoid the root
   function automatic logic is_motion(input logic signed [15:0] ax, ay, az);
      longint          sx, sy, sz;
      longint unsigned energy, upper, lower;
      sx = ax;
      sy = ay;
      sz = az;
      energy = sx * sx + sy * sy + sz * sz;
      upper  = 64'(cfg.gravity_lsb) + 64'(cfg.motion_threshold_lsb);
      if (energy > upper * upper) return 1'b1;
      if (cfg.gravity_lsb > cfg.motion_threshold_lsb) begin
         lower = 64'(cfg.gravity_lsb - cfg.motion_threshold_lsb);
         if (energy < lower * lower) return 1'b1;
      end
      return 1'b0;
   endfunction

   // advance the activity state for one accepted sample and queue its report
   task automatic classify_sample();
      logic                moving;
      logic                active;
      logic [15:0]         delta;
      logic                failed;
      activity_report_type rep;
      moving = 1'b0;
      active = 1'b0;
      delta  = '0;
      failed = 1'b0;
      if (!req_chan.accel_ok) begin
         failed = 1'b1;
      end else begin
         moving = is_motion(req_chan.accel_x, req_chan.accel_y, req_chan.accel_z);
         // leaving idle seeds the step baseline from this sample
         if (act_state == ACT_IDLE && moving) begin
            act_state    = ACT_MOVING;
            quiet_run    = '0;
            stepless_run = '0;
            if (req_chan.step_ok) step_base = req_chan.step_total;
         end
         if (act_state != ACT_IDLE) begin
            active = 1'b1;
            if (req_chan.step_ok) begin
               delta     = req_chan.step_total - step_base;
               step_base = req_chan.step_total;
               if (delta != 16'd0) begin
                  stepless_run = '0;
                  if (act_state == ACT_MOVING) act_state = ACT_WALKING;
               end else begin
                  stepless_run = sat_incr(stepless_run);
                  if (act_state == ACT_WALKING && stepless_run >= cfg.walking_timeout_count)
                     act_state = ACT_MOVING;
               end
            end
            if (moving) begin
               quiet_run = '0;
            end else begin
               quiet_run = sat_incr(quiet_run);
               if (quiet_run >= cfg.idle_confirm_count) act_state = ACT_IDLE;
            end
         end
      end
      rep.activity      = act_state;
      rep.moving_now    = moving;
      rep.active_sample = active;
      rep.step_delta    = delta;
      rep.poll_interval = (act_state == ACT_IDLE) ? cfg.idle_poll_ms : cfg.moving_poll_ms;
      rep.status        = failed;
      activity_reports.push_back(rep);
   endtask

   task automatic compare_field(input string field, input logic [15:0] expected,
                                input logic [15:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, got %0d", field, expected, actual);
         errors++;
      end
   endtask

   // compare one result transfer against the oldest report
   task automatic check_report();
      activity_report_type rep;
      if (activity_reports.size() == 0) begin
         $error("result transfer with nothing expected: activity %0d, step_delta %0d",
                rsp_chan.activity, rsp_chan.step_delta);
         errors++;
      end else begin
         rep = activity_reports.pop_front();
         compare_field("activity", 16'(rep.activity), 16'(rsp_chan.activity));
         compare_field("moving_now", 16'(rep.moving_now), 16'(rsp_chan.moving_now));
         compare_field("active_sample", 16'(rep.active_sample), 16'(rsp_chan.active_sample));
         compare_field("step_delta", rep.step_delta, rsp_chan.step_delta);
         compare_field("poll_interval", rep.poll_interval, rsp_chan.poll_interval);
         compare_field("status", 16'(rep.status), 16'(rsp_chan.status));
      end
   endtask

   // register writes, sample transfers and result transfers, in that order
   always @(posedge clock) begin
      if (reset) begin
         cfg          = '{GravityReset, ThresholdReset, IdleConfReset, WalkToutReset,
                          IdlePollReset, MovePollReset};
         act_state    = ACT_IDLE;
         quiet_run    = '0;
         stepless_run = '0;
         step_base    = '0;
         activity_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GRAVITY:   cfg.gravity_lsb           = csr_wdata[14:0];
               CSR_THRESHOLD: cfg.motion_threshold_lsb  = csr_wdata[14:0];
               CSR_IDLE_CONF: cfg.idle_confirm_count    = csr_wdata[7:0];
               CSR_WALK_TOUT: cfg.walking_timeout_count = csr_wdata[7:0];
               CSR_IDLE_POLL: cfg.idle_poll_ms          = csr_wdata;
               CSR_MOVE_POLL: cfg.moving_poll_ms        = csr_wdata;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) classify_sample();
         if (rsp_chan.valid && rsp_chan.ready) check_report();
      end
      error_count     <= errors;
      reports_pending <= activity_reports.size();
   end

endmodule

// File: dv/tb_top.sv
module tb_top;
   import asc_pkg::*;

   localparam int         LongStall  = 400;
   localparam logic [2:0] CsrPastEnd = 3'(CSR_MOVE_POLL) + 3'd1;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;
   int          error_count;
   int          reports_pending;

   asc_req_if req_chan();
   asc_rsp_if rsp_chan();

   // current settings, used only to shape the stimulus
   int          gravity_now   = 16393;
   int          threshold_now = 1000;
   int          confirm_now   = 10;
   int          timeout_now   = 10;
   logic [15:0] pedometer     = '0;

   int burst_left       = 0;
   bit no_gaps          = 1'b0;
   bit offering         = 1'b0;
   bit long_stall_req   = 1'b0;
   bit long_stall_taken = 1'b0;
   int sent             = 0;

   activity_state_classifier_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   activity_classifier_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .reports_pending (reports_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #7_500_000;
      $display("tb_top: done, errors");
      $finish;
   end

   // result side: random stalls, free-running stretches and one long hold-off
   initial begin
      int stall;
      int run_free;
      int pick;
      rsp_chan.ready <= 1'b0;
      run_free = 0;
      do @(posedge clock); while (reset);
      forever begin
         stall = 0;
         if (long_stall_req && !long_stall_taken) begin
            stall            = LongStall;
            long_stall_taken = 1'b1;
         end else if (run_free > 0) begin
            run_free--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 6)       run_free = $urandom_range(20, 80);
            else if (pick < 55) stall = 0;
            else if (pick < 92) stall = $urandom_range(1, 3);
            else                stall = $urandom_range(8, 40);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // sample side gap after each transfer
   task automatic take_gap();
      int n;
      int pick;
      n = 0;
      if (!no_gaps) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 8)       burst_left = $urandom_range(16, 64);
            else if (pick < 60) n = 0;
            else if (pick < 93) n = $urandom_range(1, 3);
            else                n = $urandom_range(10, 30);
         end
      end
      if (n > 0) begin
         req_chan.valid <= 1'b0;
         offering = 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_sample(input logic signed [15:0] ax, ay, az, input logic a_ok,
                              input logic [15:0] steps, input logic s_ok);
      req_chan.valid      <= 1'b1;
      req_chan.accel_x    <= ax;
      req_chan.accel_y    <= ay;
      req_chan.accel_z    <= az;
      req_chan.accel_ok   <= a_ok;
      req_chan.step_total <= steps;
      req_chan.step_ok    <= s_ok;
      offering = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
      take_gap();
   endtask

   // magnitude near one g on a random axis, small tilt on the others
   task automatic send_quiet(input logic [15:0] steps, input logic s_ok);
      logic signed [15:0] v [3];
      int                 lean;
      int                 mag;
      int                 tilt;
      int                 axis;
      lean = $urandom_range(0, threshold_now / 2);
      mag  = gravity_now + ($urandom_range(0, 1) ? lean : -lean);
      if (mag > 32767) mag = 32767;
      if (mag < 0) mag = 0;
      for (int i = 0; i < 3; i++) begin
         tilt = $urandom_range(0, threshold_now / 8);
         v[i] = 16'($urandom_range(0, 1) ? tilt : -tilt);
      end
      axis    = $urandom_range(0, 2);
      v[axis] = 16'($urandom_range(0, 1) ? mag : -mag);
      send_sample(v[0], v[1], v[2], 1'b1, steps, s_ok);
   endtask

   // either free fall or a hard random jolt
   task automatic send_motion(input logic [15:0] steps, input logic s_ok);
      logic signed [15:0] v [3];
      int                 fall;
      bit                 drop;
      drop = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 3; i++) begin
         fall = $urandom_range(0, gravity_now / 4);
         v[i] = drop ? 16'($urandom_range(0, 1) ? fall : -fall) : 16'($urandom);
      end
      send_sample(v[0], v[1], v[2], 1'b1, steps, s_ok);
   endtask

   // well-formed sample with occasional read failures mixed in
   task automatic send_shaped(input bit motion);
      int          pick;
      logic        s_ok;
      logic [15:0] steps;
      pick  = $urandom_range(0, 99);
      s_ok  = (pick >= 5);
      steps = s_ok ? pedometer : 16'($urandom);
      if (pick >= 5 && pick < 10)
         send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, steps, 1'b1);
      else if (motion)
         send_motion(steps, s_ok);
      else
         send_quiet(steps, s_ok);
   endtask

   // rest, walk, stand still while moving, then settle back to rest; or noise
   task automatic run_episode();
      int lead;
      int walk;
      int still;
      int tail;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(4, 20))
            send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                        1'($urandom_range(0, 3) != 0), 16'($urandom),
                        1'($urandom_range(0, 1)));
         pedometer = ($urandom_range(0, 3) == 0) ? 16'(65535 - $urandom_range(0, 6))
                                                 : 16'($urandom);
      end else begin
         lead  = $urandom_range(0, 3);
         walk  = $urandom_range(1, 12);
         still = (timeout_now > 200) ? $urandom_range(240, 300)
                                     : $urandom_range(0, timeout_now + 3);
         tail  = $urandom_range((confirm_now > 1) ? confirm_now - 1 : 1, confirm_now + 1);
         repeat (lead) send_shaped(1'b0);
         repeat (walk) begin
            pedometer += 16'($urandom_range(0, 3));
            send_shaped($urandom_range(0, 4) != 0);
         end
         repeat (still) send_shaped(1'b1);
         repeat (tail) send_shaped(1'b0);
      end
   endtask

   task automatic run_phase(input int count);
      int start;
      start = sent;
      while (sent - start < count) run_episode();
   endtask

   // stop offering and wait until every report has come back
   task automatic drain();
      if (offering) begin
         req_chan.valid <= 1'b0;
         offering = 1'b0;
      end
      do @(posedge clock); while (reports_pending != 0);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int g, t, conf, tout, ipoll, mpoll);
      drain();
      csr_write(CSR_GRAVITY, 16'(g));
      csr_write(CSR_THRESHOLD, 16'(t));
      csr_write(CSR_IDLE_CONF, 16'(conf));
      csr_write(CSR_WALK_TOUT, 16'(tout));
      csr_write(CSR_IDLE_POLL, 16'(ipoll));
      csr_write(CSR_MOVE_POLL, 16'(mpoll));
      gravity_now   = g & 32'h7fff;
      threshold_now = t & 32'h7fff;
      confirm_now   = conf & 32'hff;
      timeout_now   = tout & 32'hff;
   endtask

   initial begin
      int g;
      int t;
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= CSR_GRAVITY;
      csr_wdata           <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.accel_x    <= '0;
      req_chan.accel_y    <= '0;
      req_chan.accel_z    <= '0;
      req_chan.accel_ok   <= 1'b0;
      req_chan.step_total <= '0;
      req_chan.step_ok    <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: quiet idle, failed read, free fall with failed step read
      send_sample(16'sd0, 16'sd0, 16'sd16393, 1'b1, 16'd40, 1'b1);
      send_sample(-16'sd32768, 16'sd32767, 16'sd1, 1'b0, 16'hffff, 1'b1);
      send_sample(16'sd0, 16'sd0, 16'sd0, 1'b1, 16'h5a5a, 1'b0);
      // axis extremes, step count wraps through zero
      send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 16'hffff, 1'b1);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 16'd1, 1'b1);
      send_sample(16'sd12, -16'sd7, 16'sd3, 1'b0, 16'd1, 1'b1);
      send_sample(16'sd20000, 16'sd0, 16'sd0, 1'b1, 16'd1, 1'b1);
      send_sample(16'sd20000, 16'sd0, 16'sd0, 1'b1, 16'd7, 1'b0);
      send_sample(16'sd0, 16'sd0, 16'sd16393, 1'b1, 16'd1, 1'b1);

      // zero confirm and timeout counts
      set_config(16393, 1000, 0, 0, 1000, 100);
      send_sample(16'sd20000, 16'sd0, 16'sd0, 1'b1, 16'd1, 1'b1);
      send_sample(16'sd0, 16'sd0, -16'sd16393, 1'b1, 16'd1, 1'b1);

      // threshold above gravity: only the upper bound counts, edge of the window
      set_config(100, 200, 0, 0, 1000, 100);
      send_sample(16'sd0, 16'sd0, 16'sd0, 1'b1, 16'd3, 1'b1);
      send_sample(16'sd0, 16'sd0, 16'sd300, 1'b1, 16'd3, 1'b1);
      send_sample(16'sd0, 16'sd0, 16'sd301, 1'b1, 16'd9, 1'b1);

      // widest window, data bits above each register are dropped
      set_config(16'hffff, 16'hffff, 16'hff00, 16'hff00, 16'hffff, 16'h0001);
      send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 16'd9, 1'b1);

      // zero threshold: only exactly one g is quiet
      set_config(32767, 0, 0, 0, 1, 65535);
      send_sample(16'sd0, 16'sd0, 16'sd32767, 1'b1, 16'd9, 1'b1);
      send_sample(16'sd0, 16'sd0, -16'sd32768, 1'b1, 16'd9, 1'b1);
      send_sample(16'sd0, 16'sd32766, 16'sd0, 1'b1, 16'd12, 1'b1);

      // zero gravity, writes past the last register are ignored
      set_config(0, 0, 0, 0, 0, 0);
      csr_write(CsrPastEnd, 16'h7fff);
      csr_write(CsrPastEnd + 3'd1, 16'h1234);
      send_sample(16'sd0, 16'sd0, 16'sd0, 1'b1, 16'd12, 1'b1);
      send_sample(16'sd0, 16'sd0, 16'sd1, 1'b1, 16'd12, 1'b1);
      send_sample(16'sd0, 16'sd0, 16'sd0, 1'b1, 16'd12, 1'b1);

      // random episodes under several settings
      set_config(16393, 1000, 4, 3, 1000, 100);
      run_phase(350);
      set_config(16393, 2000, 1, 1, 500, 50);
      run_phase(300);
      set_config(16393, 1000, 255, 255, 65535, 1);
      run_phase(600);
      repeat (4) begin
         g = $urandom_range(2000, 20000);
         t = ($urandom_range(0, 2) == 0) ? $urandom_range(g, 32767) : $urandom_range(0, g / 4);
         set_config(g, t, $urandom_range(1, 8), $urandom_range(1, 8),
                    $urandom_range(1, 65535), $urandom_range(1, 65535));
         run_phase(100);
      end

      // back-to-back samples while the result side holds off
      set_config(16393, 1000, 3, 3, 250, 25);
      no_gaps        = 1'b1;
      long_stall_req = 1'b1;
      run_phase(150);
      no_gaps = 1'b0;
      run_phase(100);

      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
